[sv/clr_pkg.sv]
// Shared constants and types for the clipped line rasterizer.
`timescale 1ns / 1ps
package clr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int DISPLAY_MAX_DEF = 1024;

  localparam int VIEW_OFS_BITS  = 12;
  localparam int VIEW_SIZE_BITS = 11;
  localparam int DISP_SIZE_BITS = 11;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_IDX_BITS   = 3;
  localparam int COLOR_BITS     = 16;
  localparam int PIX_BITS       = 10;
  localparam int ADDR_BITS      = 20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VIEWPORT_X      = 3'd0,
    CFG_VIEWPORT_Y      = 3'd1,
    CFG_VIEWPORT_WIDTH  = 3'd2,
    CFG_VIEWPORT_HEIGHT = 3'd3,
    CFG_DISPLAY_WIDTH   = 3'd4,
    CFG_DISPLAY_HEIGHT  = 3'd5
  } clr_cfg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } clr_op_t;

  localparam logic [VIEW_SIZE_BITS-1:0] VIEWPORT_WIDTH_RST  = 11'd240;
  localparam logic [VIEW_SIZE_BITS-1:0] VIEWPORT_HEIGHT_RST = 11'd320;
  localparam logic [DISP_SIZE_BITS-1:0] DISPLAY_WIDTH_RST   = 11'd240;
  localparam logic [DISP_SIZE_BITS-1:0] DISPLAY_HEIGHT_RST  = 11'd320;

  typedef struct packed {
    logic active;
    logic at_end;
  } clr_line_status_t;

endpackage

[sv/clr_stepper.sv]
// Bresenham line state: endpoint load and one-pixel advance per step.
`timescale 1ns / 1ps
module clr_stepper #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic                             step,
  input  logic signed [COORD_BITS-1:0]     x_start,
  input  logic signed [COORD_BITS-1:0]     y_start,
  input  logic signed [COORD_BITS-1:0]     x_end,
  input  logic signed [COORD_BITS-1:0]     y_end,
  input  logic [clr_pkg::COLOR_BITS-1:0]   pen_color,
  output logic signed [COORD_BITS-1:0]     cur_x,
  output logic signed [COORD_BITS-1:0]     cur_y,
  output logic [clr_pkg::COLOR_BITS-1:0]   line_color,
  output clr_pkg::clr_line_status_t        status
);
  import clr_pkg::*;

  localparam int EB = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0]        dx_abs_r, dx_abs_nxt, dy_abs_r, dy_abs_nxt;
  logic signed [EB-1:0]         err_r, err_nxt;
  logic                         sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic                         x_major_r, x_major_nxt;
  logic                         active_r, active_nxt;
  logic [COLOR_BITS-1:0]        color_r, color_nxt;

  logic signed [COORD_BITS:0]   dx_ld, dy_ld, dx_mag, dy_mag;
  logic [COORD_BITS-1:0]        dxa_ld, dya_ld, maj_ld, dmaj, dmin;
  logic                         x_major_ld, at_end, minor_step;
  logic [EB-1:0]                err_add, err_sub;
  logic [COORD_BITS-1:0]        step_x, step_y;

  assign dx_ld  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
  assign dy_ld  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
  assign dx_mag = dx_ld[COORD_BITS] ? -dx_ld : dx_ld;
  assign dy_mag = dy_ld[COORD_BITS] ? -dy_ld : dy_ld;
  assign dxa_ld = dx_mag[COORD_BITS-1:0];
  assign dya_ld = dy_mag[COORD_BITS-1:0];
  assign x_major_ld = (dxa_ld >= dya_ld);
  assign maj_ld = x_major_ld ? dxa_ld : dya_ld;

  assign at_end = x_major_r ? (cur_x_r == tgt_x_r) : (cur_y_r == tgt_y_r);
  assign dmaj   = x_major_r ? dx_abs_r : dy_abs_r;
  assign dmin   = x_major_r ? dy_abs_r : dx_abs_r;

  assign err_add    = err_r + {2'b00, dmin, 1'b0};
  assign minor_step = ~err_add[EB-1];
  assign err_sub    = err_add - {2'b00, dmaj, 1'b0};

  assign step_x = sx_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
  assign step_y = sy_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    tgt_x_nxt   = tgt_x_r;
    tgt_y_nxt   = tgt_y_r;
    dx_abs_nxt  = dx_abs_r;
    dy_abs_nxt  = dy_abs_r;
    err_nxt     = err_r;
    sx_neg_nxt  = sx_neg_r;
    sy_neg_nxt  = sy_neg_r;
    x_major_nxt = x_major_r;
    active_nxt  = active_r;
    color_nxt   = color_r;
    if (load) begin
      cur_x_nxt   = x_start;
      cur_y_nxt   = y_start;
      tgt_x_nxt   = x_end;
      tgt_y_nxt   = y_end;
      dx_abs_nxt  = dxa_ld;
      dy_abs_nxt  = dya_ld;
      sx_neg_nxt  = dx_ld[COORD_BITS];
      sy_neg_nxt  = dy_ld[COORD_BITS];
      x_major_nxt = x_major_ld;
      err_nxt     = EB'(0) - {3'b000, maj_ld};
      color_nxt   = pen_color;
      active_nxt  = 1'b1;
    end else if (step && active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = minor_step ? err_sub : err_add;
        if (x_major_r) begin
          cur_x_nxt = cur_x_r + step_x;
          if (minor_step) cur_y_nxt = cur_y_r + step_y;
        end else begin
          cur_y_nxt = cur_y_r + step_y;
          if (minor_step) cur_x_nxt = cur_x_r + step_x;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      tgt_x_r   <= '0;
      tgt_y_r   <= '0;
      dx_abs_r  <= '0;
      dy_abs_r  <= '0;
      err_r     <= '0;
      sx_neg_r  <= 1'b0;
      sy_neg_r  <= 1'b0;
      x_major_r <= 1'b0;
      active_r  <= 1'b0;
      color_r   <= '0;
    end else begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      tgt_x_r   <= tgt_x_nxt;
      tgt_y_r   <= tgt_y_nxt;
      dx_abs_r  <= dx_abs_nxt;
      dy_abs_r  <= dy_abs_nxt;
      err_r     <= err_nxt;
      sx_neg_r  <= sx_neg_nxt;
      sy_neg_r  <= sy_neg_nxt;
      x_major_r <= x_major_nxt;
      active_r  <= active_nxt;
      color_r   <= color_nxt;
    end
  end

  assign cur_x         = cur_x_r;
  assign cur_y         = cur_y_r;
  assign line_color    = color_r;
  assign status.active = active_r;
  assign status.at_end = at_end;

endmodule

[sv/clr_clip.sv]
// Viewport and display clipping of one point, and its frame-buffer address.
`timescale 1ns / 1ps
module clr_clip #(
  parameter int COORD_BITS  = clr_pkg::COORD_BITS_DEF,
  parameter int DISPLAY_MAX = clr_pkg::DISPLAY_MAX_DEF
) (
  input  logic signed [COORD_BITS-1:0]             px,
  input  logic signed [COORD_BITS-1:0]             py,
  input  logic signed [clr_pkg::VIEW_OFS_BITS-1:0] viewport_x,
  input  logic signed [clr_pkg::VIEW_OFS_BITS-1:0] viewport_y,
  input  logic [clr_pkg::VIEW_SIZE_BITS-1:0]       viewport_width,
  input  logic [clr_pkg::VIEW_SIZE_BITS-1:0]       viewport_height,
  input  logic [clr_pkg::DISP_SIZE_BITS-1:0]       display_width,
  input  logic [clr_pkg::DISP_SIZE_BITS-1:0]       display_height,
  output logic                                     keep,
  output logic [clr_pkg::PIX_BITS-1:0]             pixel_x,
  output logic [clr_pkg::PIX_BITS-1:0]             pixel_y,
  output logic [clr_pkg::ADDR_BITS-1:0]            pixel_address
);
  import clr_pkg::*;

  localparam int CB0 = (COORD_BITS > VIEW_OFS_BITS) ? COORD_BITS : VIEW_OFS_BITS;
  localparam int SW  = CB0 + 2;
  localparam int DW  = $clog2(DISPLAY_MAX + 1);
  localparam int DCW = ((DW > DISP_SIZE_BITS) ? DW : DISP_SIZE_BITS) + 1;
  localparam int PW  = 2 * DW;

  logic signed [SW-1:0] px_e, py_e, vw_e, vh_e, px_d, py_d, dw_s, dh_s;
  logic [DCW-1:0]       dwi, dhi, dmax;
  logic [DW-1:0]        dw_c, dh_c;
  logic                 in_view, in_disp;
  logic [PW-1:0]        prod;
  logic [PW:0]          addr_full;

  assign px_e = SW'(px);
  assign py_e = SW'(py);
  assign vw_e = SW'({1'b0, viewport_width});
  assign vh_e = SW'({1'b0, viewport_height});
  assign px_d = px_e + SW'(viewport_x);
  assign py_d = py_e + SW'(viewport_y);

  assign dwi  = DCW'(display_width);
  assign dhi  = DCW'(display_height);
  assign dmax = DCW'(DISPLAY_MAX);
  assign dw_c = (dwi > dmax) ? DW'(dmax) : DW'(dwi);
  assign dh_c = (dhi > dmax) ? DW'(dmax) : DW'(dhi);
  assign dw_s = SW'({1'b0, dw_c});
  assign dh_s = SW'({1'b0, dh_c});

  assign in_view = (px_e < vw_e) && (py_e < vh_e);
  assign in_disp = !px_d[SW-1] && !py_d[SW-1] && (px_d < dw_s) && (py_d < dh_s);
  assign keep    = in_view && in_disp;

  assign prod      = py_d[DW-1:0] * dw_c;
  assign addr_full = {1'b0, prod} + (PW+1)'(px_d[DW-1:0]);

  assign pixel_x       = keep ? px_d[PIX_BITS-1:0] : '0;
  assign pixel_y       = keep ? py_d[PIX_BITS-1:0] : '0;
  assign pixel_address = keep ? ADDR_BITS'(addr_full) : '0;

endmodule

[sv/clipped_line_rasterizer.sv]
// Top level: configuration registers, handshake, line stepper, clip and result register.
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per clock; each transfer updates the result register, and loads
// and active steps the stepper; a held result stalls input only while out_stall is high.
// Reset: viewport and display registers take their defaults, no line is active and
// the result register is empty.
`timescale 1ns / 1ps
module clipped_line_rasterizer #(
  parameter int COORD_BITS  = clr_pkg::COORD_BITS_DEF,
  parameter int DISPLAY_MAX = clr_pkg::DISPLAY_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [clr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [clr_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic signed [COORD_BITS-1:0]          in_x_start,
  input  logic signed [COORD_BITS-1:0]          in_y_start,
  input  logic signed [COORD_BITS-1:0]          in_x_end,
  input  logic signed [COORD_BITS-1:0]          in_y_end,
  input  logic [clr_pkg::COLOR_BITS-1:0]        in_pen_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_write_enable,
  output logic [clr_pkg::PIX_BITS-1:0]          out_pixel_x,
  output logic [clr_pkg::PIX_BITS-1:0]          out_pixel_y,
  output logic [clr_pkg::ADDR_BITS-1:0]         out_pixel_address,
  output logic [clr_pkg::COLOR_BITS-1:0]        out_pixel_color,
  output logic                                  out_last,
  output logic                                  out_busy_res
);
  import clr_pkg::*;

  logic signed [VIEW_OFS_BITS-1:0] vx_r, vy_r;
  logic [VIEW_SIZE_BITS-1:0]       vw_r, vh_r;
  logic [DISP_SIZE_BITS-1:0]       dw_r, dh_r;

  logic                    out_valid_r, out_valid_nxt;
  logic                    we_r, we_nxt, last_r, last_nxt, busy_r, busy_nxt;
  logic [PIX_BITS-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic [ADDR_BITS-1:0]    addr_r, addr_nxt;
  logic [COLOR_BITS-1:0]   color_r, color_nxt;

  logic                          xfer, load, step;
  logic signed [COORD_BITS-1:0]  cur_x, cur_y;
  logic [COLOR_BITS-1:0]         line_color;
  clr_line_status_t              status;
  logic                          keep;
  logic [PIX_BITS-1:0]           clip_x, clip_y;
  logic [ADDR_BITS-1:0]          clip_addr;

  assign in_stall = out_valid_r && out_stall;
  assign xfer     = in_valid && !in_stall;
  assign load     = xfer && (in_operation == OP_LOAD);
  assign step     = xfer && (in_operation == OP_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      vy_r <= '0;
      vw_r <= VIEWPORT_WIDTH_RST;
      vh_r <= VIEWPORT_HEIGHT_RST;
      dw_r <= DISPLAY_WIDTH_RST;
      dh_r <= DISPLAY_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEWPORT_X:      vx_r <= cfg_wdata[VIEW_OFS_BITS-1:0];
        CFG_VIEWPORT_Y:      vy_r <= cfg_wdata[VIEW_OFS_BITS-1:0];
        CFG_VIEWPORT_WIDTH:  vw_r <= cfg_wdata[VIEW_SIZE_BITS-1:0];
        CFG_VIEWPORT_HEIGHT: vh_r <= cfg_wdata[VIEW_SIZE_BITS-1:0];
        CFG_DISPLAY_WIDTH:   dw_r <= cfg_wdata[DISP_SIZE_BITS-1:0];
        CFG_DISPLAY_HEIGHT:  dh_r <= cfg_wdata[DISP_SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  clr_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .step       (step),
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .pen_color  (in_pen_color),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .line_color (line_color),
    .status     (status)
  );

  clr_clip #(
    .COORD_BITS  (COORD_BITS),
    .DISPLAY_MAX (DISPLAY_MAX)
  ) u_clip (
    .px              (cur_x),
    .py              (cur_y),
    .viewport_x      (vx_r),
    .viewport_y      (vy_r),
    .viewport_width  (vw_r),
    .viewport_height (vh_r),
    .display_width   (dw_r),
    .display_height  (dh_r),
    .keep            (keep),
    .pixel_x         (clip_x),
    .pixel_y         (clip_y),
    .pixel_address   (clip_addr)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    we_nxt        = we_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    addr_nxt      = addr_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    busy_nxt      = busy_r;
    if (xfer) begin
      out_valid_nxt = 1'b1;
      we_nxt        = 1'b0;
      px_nxt        = '0;
      py_nxt        = '0;
      addr_nxt      = '0;
      color_nxt     = '0;
      last_nxt      = 1'b0;
      busy_nxt      = 1'b0;
      if (load) begin
        busy_nxt = 1'b1;
      end else if (status.active) begin
        we_nxt    = keep;
        px_nxt    = clip_x;
        py_nxt    = clip_y;
        addr_nxt  = clip_addr;
        color_nxt = keep ? line_color : '0;
        last_nxt  = status.at_end;
        busy_nxt  = !status.at_end;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    we_r    <= we_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    addr_r  <= addr_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
    busy_r  <= busy_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = we_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_last          = last_r;
  assign out_busy_res      = busy_r;

endmodule
